// File: rtl/json_string_unescape_utf8_top_defines.svh
// Assertion macros for the JSON string unescaper.
// Used by json_string_unescape_utf8_top; no other dependencies.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define JSU_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JSU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JSU_ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define JSU_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/jsu_pkg.sv
// Shared types, constants and the UTF-8 encoder for the JSON string unescaper.
// No dependencies.
`default_nettype none

package jsu_pkg;

  localparam int unsigned CAPACITY_MAX = 4096;
  localparam int unsigned CAP_W        = 13;
  localparam int unsigned MAX_ITEMS    = 6;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned CP_W         = 21;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD  = 1'b1;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             discard;
  } cfg_t;

  typedef struct packed {
    logic            en;
    logic            raw;
    logic [CP_W-1:0] cp;
  } seg_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  typedef struct packed {
    logic [MAX_ITEMS-1:0][7:0] bytes;
    logic [CNT_W-1:0]          nbytes;
    logic                      fin;
    logic                      bad;
  } result_t;

  function automatic utf8_t utf8_encode(seg_t s);
    utf8_t r;
    r.len = '0;
    r.b   = '0;
    if (s.en) begin
      if (s.raw || s.cp < 21'h80) begin
        r.len  = 3'd1;
        r.b[0] = s.cp[7:0];
      end else if (s.cp < 21'h800) begin
        r.len  = 3'd2;
        r.b[0] = {3'b110, s.cp[10:6]};
        r.b[1] = {2'b10, s.cp[5:0]};
      end else if (s.cp < 21'h10000) begin
        r.len  = 3'd3;
        r.b[0] = {4'b1110, s.cp[15:12]};
        r.b[1] = {2'b10, s.cp[11:6]};
        r.b[2] = {2'b10, s.cp[5:0]};
      end else begin
        r.len  = 3'd4;
        r.b[0] = {5'b11110, s.cp[20:18]};
        r.b[1] = {2'b10, s.cp[17:12]};
        r.b[2] = {2'b10, s.cp[11:6]};
        r.b[3] = {2'b10, s.cp[5:0]};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_decode.sv
// Escape state machine and capacity gate: turns one held input byte into a
// bundle of up to six result items. Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic [7:0]       chr_i,
  input  wire jsu_pkg::cfg_t    cfg_i,
  output jsu_pkg::result_t      res_o
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_AWAIT   = 3'd0;
  localparam logic [2:0] PH_BODY    = 3'd1;
  localparam logic [2:0] PH_ESC     = 3'd2;
  localparam logic [2:0] PH_HEX1    = 3'd3;
  localparam logic [2:0] PH_WAIT_BS = 3'd4;
  localparam logic [2:0] PH_WAIT_U  = 3'd5;
  localparam logic [2:0] PH_HEX2    = 3'd6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_U     = 8'h75;

  logic [2:0]       phase_q, phase_d;
  logic [15:0]      acc_q, acc_d;
  logic [1:0]       hcnt_q, hcnt_d;
  logic [15:0]      pend_q, pend_d;
  logic [CAP_W-1:0] bw_q, bw_d;

  logic             hok;
  logic [3:0]       hval;
  logic [15:0]      acc_n;
  logic             esc_ok;
  logic [7:0]       esc_d;
  logic             do_body, do_esc, do_finish, do_reject, bw_reset;
  logic [15:0]      fin_cp;
  seg_t             seg_a, seg_b;
  logic             fin, bad;
  utf8_t            ea, eb;
  logic [MAX_ITEMS-1:0][7:0] bytes;
  logic [CNT_W-1:0] nraw, emit;
  logic [CAP_W-1:0] cap_eff, bw_p1, room;

  always_comb begin
    hok  = 1'b1;
    hval = 4'd0;
    if (chr_i >= 8'h30 && chr_i <= 8'h39) begin
      hval = chr_i[3:0];
    end else if ((chr_i >= 8'h61 && chr_i <= 8'h66) || (chr_i >= 8'h41 && chr_i <= 8'h46)) begin
      hval = 4'(chr_i[2:0] + 3'd1) + 4'd8;
    end else begin
      hok = 1'b0;
    end
  end

  assign acc_n = {acc_q[11:0], hval};

  always_comb begin
    esc_ok = 1'b1;
    esc_d  = 8'h00;
    case (chr_i)
      CH_QUOTE: esc_d = CH_QUOTE;
      CH_BSL:   esc_d = CH_BSL;
      CH_SLASH: esc_d = CH_SLASH;
      CH_N:     esc_d = 8'h0A;
      CH_R:     esc_d = 8'h0D;
      CH_T:     esc_d = 8'h09;
      CH_B:     esc_d = 8'h08;
      CH_F:     esc_d = 8'h0C;
      default:  esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    hcnt_d    = hcnt_q;
    pend_d    = pend_q;
    seg_a     = '0;
    seg_b     = '0;
    fin       = 1'b0;
    bad       = 1'b0;
    bw_reset  = 1'b0;
    do_body   = 1'b0;
    do_esc    = 1'b0;
    do_finish = 1'b0;
    do_reject = 1'b0;
    fin_cp    = acc_n;

    unique case (phase_q)
      PH_AWAIT: begin
        if (chr_i == CH_QUOTE) begin
          phase_d  = PH_BODY;
          bw_reset = 1'b1;
          acc_d    = '0;
          hcnt_d   = '0;
          pend_d   = '0;
        end else begin
          do_reject = 1'b1;
        end
      end
      PH_BODY: do_body = 1'b1;
      PH_ESC:  do_esc  = 1'b1;
      PH_HEX1, PH_HEX2: begin
        if (!hok) begin
          do_reject = 1'b1;
        end else begin
          acc_d  = acc_n;
          hcnt_d = hcnt_q + 2'd1;
          if (hcnt_q == 2'd3) begin
            if (phase_q == PH_HEX1) begin
              do_finish = 1'b1;
            end else begin
              pend_d   = '0;
              seg_a.en = 1'b1;
              if (acc_n[15:10] == LO_SURR_TAG) begin
                seg_a.cp = 21'h10000 + {1'b0, pend_q[9:0], acc_n[9:0]};
                phase_d  = PH_BODY;
              end else begin
                seg_a.cp  = {5'd0, pend_q};
                do_finish = 1'b1;
              end
            end
          end
        end
      end
      PH_WAIT_BS: begin
        if (chr_i == CH_BSL) begin
          phase_d = PH_WAIT_U;
        end else begin
          seg_a.en = 1'b1;
          seg_a.cp = {5'd0, pend_q};
          pend_d   = '0;
          do_body  = 1'b1;
        end
      end
      PH_WAIT_U: begin
        if (chr_i == CH_U) begin
          phase_d = PH_HEX2;
          acc_d   = '0;
          hcnt_d  = '0;
        end else begin
          seg_a.en = 1'b1;
          seg_a.cp = {5'd0, pend_q};
          pend_d   = '0;
          do_esc   = 1'b1;
        end
      end
      default: do_reject = 1'b1;
    endcase

    if (do_finish) begin
      if (fin_cp[15:10] == HI_SURR_TAG) begin
        pend_d  = fin_cp;
        phase_d = PH_WAIT_BS;
      end else begin
        seg_b.en = 1'b1;
        seg_b.cp = {5'd0, fin_cp};
        phase_d  = PH_BODY;
      end
    end

    if (do_body) begin
      phase_d = PH_BODY;
      if (chr_i == CH_QUOTE) begin
        phase_d = PH_AWAIT;
        fin     = 1'b1;
      end else if (chr_i == CH_NUL) begin
        do_reject = 1'b1;
      end else if (chr_i == CH_BSL) begin
        phase_d = PH_ESC;
      end else begin
        seg_b.en  = 1'b1;
        seg_b.raw = 1'b1;
        seg_b.cp  = {13'd0, chr_i};
      end
    end

    if (do_esc) begin
      if (esc_ok) begin
        seg_b.en = 1'b1;
        seg_b.cp = {13'd0, esc_d};
        phase_d  = PH_BODY;
      end else if (chr_i == CH_U) begin
        phase_d = PH_HEX1;
        acc_d   = '0;
        hcnt_d  = '0;
      end else begin
        do_reject = 1'b1;
      end
    end

    if (do_reject) begin
      phase_d = PH_AWAIT;
      acc_d   = '0;
      hcnt_d  = '0;
      pend_d  = '0;
      bad     = 1'b1;
    end
  end

  assign ea = utf8_encode(seg_a);
  assign eb = utf8_encode(seg_b);

  always_comb begin
    logic [2:0] kk;
    logic [2:0] j;
    for (int k = 0; k < MAX_ITEMS; k++) begin
      kk = 3'(k);
      j  = kk - ea.len;
      if (kk < ea.len) begin
        bytes[k] = ea.b[kk[1:0]];
      end else if (j < 3'd4) begin
        bytes[k] = eb.b[j[1:0]];
      end else begin
        bytes[k] = 8'h00;
      end
    end
  end

  assign nraw    = CNT_W'(ea.len + eb.len);
  assign cap_eff = (cfg_i.capacity > CAP_W'(CAPACITY_MAX)) ? CAP_W'(CAPACITY_MAX)
                                                            : cfg_i.capacity;
  assign bw_p1   = bw_q + CAP_W'(1);
  assign room    = (cap_eff > bw_p1) ? cap_eff - bw_p1 : '0;
  assign emit    = cfg_i.discard ? '0
                 : (room < CAP_W'(nraw)) ? room[CNT_W-1:0] : nraw;
  assign bw_d    = bw_reset ? '0 : bw_q + CAP_W'(emit);

  assign res_o.bytes  = bytes;
  assign res_o.nbytes = emit;
  assign res_o.fin    = fin;
  assign res_o.bad    = bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT;
      acc_q   <= '0;
      hcnt_q  <= '0;
      pend_q  <= '0;
      bw_q    <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hcnt_q  <= hcnt_d;
      pend_q  <= pend_d;
      bw_q    <= bw_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/jsu_result_buf.sv
// Result register: holds the items of one input byte and hands them out one
// transaction per cycle while out_ready is high. Depends on jsu_pkg.
`default_nettype none

module jsu_result_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire jsu_pkg::result_t  res_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   finished_o,
  output logic                   malformed_o,
  output logic                   last_o
);
  import jsu_pkg::*;

  logic [MAX_ITEMS-1:0][7:0] byte_q;
  logic [CNT_W-1:0]          nb_q;
  logic                      fin_q, bad_q;
  logic [CNT_W-1:0]          rd_q, tot_q, tot_d, rd_p1;
  logic                      take, is_byte;

  assign tot_d       = res_i.nbytes + CNT_W'(res_i.fin | res_i.bad);
  assign rd_p1       = rd_q + CNT_W'(1);
  assign out_valid_o = (rd_q != tot_q);
  assign take        = out_valid_o & out_ready_i;
  assign can_load_o  = !out_valid_o || (take && rd_p1 == tot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      tot_q <= '0;
    end else if (load_i) begin
      rd_q  <= '0;
      tot_q <= tot_d;
    end else if (take) begin
      rd_q  <= rd_p1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= res_i.bytes;
      nb_q   <= res_i.nbytes;
      fin_q  <= res_i.fin;
      bad_q  <= res_i.bad;
    end
  end

  assign is_byte      = (rd_q < nb_q);
  assign out_byte_o   = is_byte ? byte_q[rd_q] : 8'h00;
  assign byte_valid_o = is_byte;
  assign finished_o   = !is_byte & fin_q;
  assign malformed_o  = !is_byte & bad_q;
  assign last_o       = (rd_p1 == tot_q);

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper: configuration registers, input
// register and assertions. Depends on jsu_pkg, jsu_decode, jsu_result_buf.
//
// Feed a quoted JSON string one byte per input transaction, opening quote
// first; decoded UTF-8 bytes come out one per output transaction, followed
// by a finished item at the closing quote or a malformed item on a bad
// string, with last marking the final item of each input byte. An input
// byte passes the input register and is decoded into the result register,
// so its first item appears once the result register has loaded it. While
// out_ready is high the input side takes one byte per cycle as long as each
// byte gives at most one item; a byte with more (up to six for a split
// surrogate pair) holds the input while the result register hands them out
// one per cycle. Write configuration only while no transaction is in flight.
`default_nettype none

module json_string_unescape_utf8_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [jsu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [jsu_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        in_char_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [7:0]                             out_byte_o,
  output logic                                   byte_valid_o,
  output logic                                   finished_o,
  output logic                                   malformed_o,
  output logic                                   last_o
);
  import jsu_pkg::*;

`include "json_string_unescape_utf8_top_defines.svh"

  cfg_t       cfg_q;
  logic [7:0] in_char_q;
  logic       in_vld_q;
  logic       can_load, adv;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= CAP_W'(256);
      cfg_q.discard  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY: cfg_q.capacity <= cfg_wdata_i;
        CFG_DISCARD:  cfg_q.discard  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign adv        = in_vld_q & can_load;
  assign in_ready_o = !in_vld_q | can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= in_char_i;
    end
  end

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .chr_i  (in_char_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  jsu_result_buf u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (adv),
    .res_i        (res),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .finished_o   (finished_o),
    .malformed_o  (malformed_o),
    .last_o       (last_o)
  );

  `JSU_ASSERT_IMPLY(a_flag_is_last, clk_i, rst_ni, out_valid_o && (finished_o || malformed_o), last_o)
  `JSU_ASSERT_IMPLY(a_single_flag, clk_i, rst_ni, out_valid_o, !(finished_o && malformed_o))
  `JSU_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, adv && (res.nbytes != '0 || res.fin || res.bad), out_valid_o)
  `JSU_ASSERT_NEXT(a_hold_input, clk_i, rst_ni, in_vld_q && !can_load, in_vld_q)

endmodule

`default_nettype wire

// File: dv/jsu_unescape_checker.sv
// Scoreboard for the JSON string unescaper: tracks register writes, decodes every accepted
// input byte into the UTF-8 and flag items it should produce, and matches output transactions.
// Depends on jsu_pkg for the register indexes, widths and the capacity bound.
module jsu_unescape_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jsu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [jsu_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    in_char_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [7:0]                    out_byte_i,
  input  logic                          byte_valid_i,
  input  logic                          finished_i,
  input  logic                          malformed_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam int unsigned HI_SURR_FIRST = 32'hD800;
  localparam int unsigned HI_SURR_LAST  = 32'hDBFF;
  localparam int unsigned LO_SURR_FIRST = 32'hDC00;
  localparam int unsigned LO_SURR_LAST  = 32'hDFFF;

  typedef enum logic [2:0] {
    ST_AWAIT_QUOTE,
    ST_BODY,
    ST_ESCAPE,
    ST_HEX_FIRST,
    ST_WAIT_BSLASH,
    ST_WAIT_U,
    ST_HEX_SECOND
  } scan_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       fin;
    logic       bad;
    logic       lst;
  } decoded_t;

  scan_state_e         scan_st;
  logic [15:0]         hex_acc;
  logic [2:0]          hex_cnt;
  int unsigned         high_surr;
  int unsigned         n_written;
  logic [jsu_pkg::CAP_W-1:0] capacity;
  logic                discard;

  decoded_t            step_items[$];
  decoded_t            decoded_q[$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  function automatic void add_result(logic [7:0] b, logic v, logic f, logic m);
    decoded_t d;
    if (step_items.size() >= jsu_pkg::MAX_ITEMS) return;
    d.data   = b;
    d.dvalid = v;
    d.fin    = f;
    d.bad    = m;
    d.lst    = 1'b0;
    step_items.push_back(d);
  endfunction

  function automatic void emit_byte(int unsigned b);
    int unsigned limit;
    limit = (capacity > jsu_pkg::CAPACITY_MAX) ? jsu_pkg::CAPACITY_MAX
                                               : {19'd0, capacity};
    if (discard) return;
    if (n_written + 1 < limit) begin
      add_result(b[7:0], 1'b1, 1'b0, 1'b0);
      n_written++;
    end
  endfunction

  function automatic void emit_code_point(int unsigned cp);
    if (cp < 32'h80) begin
      emit_byte(cp);
    end else if (cp < 32'h800) begin
      emit_byte(32'hC0 | (cp >> 6));
      emit_byte(32'h80 | (cp & 32'h3F));
    end else if (cp < 32'h10000) begin
      emit_byte(32'hE0 | (cp >> 12));
      emit_byte(32'h80 | ((cp >> 6) & 32'h3F));
      emit_byte(32'h80 | (cp & 32'h3F));
    end else begin
      emit_byte(32'hF0 | ((cp >> 18) & 32'h07));
      emit_byte(32'h80 | ((cp >> 12) & 32'h3F));
      emit_byte(32'h80 | ((cp >> 6) & 32'h3F));
      emit_byte(32'h80 | (cp & 32'h3F));
    end
  endfunction

  function automatic void drop_string();
    scan_st   = ST_AWAIT_QUOTE;
    hex_acc   = '0;
    hex_cnt   = '0;
    high_surr = 0;
    add_result(8'h00, 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 32'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 32'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 32'h41 + 10;
    return -1;
  endfunction

  function automatic void body_byte(logic [7:0] c);
    if (c == CH_QUOTE) begin
      scan_st = ST_AWAIT_QUOTE;
      add_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else if (c == 8'h00) begin
      drop_string();
    end else if (c == CH_BSLASH) begin
      scan_st = ST_ESCAPE;
    end else begin
      emit_byte({24'd0, c});
    end
  endfunction

  function automatic void escape_byte(logic [7:0] c);
    int unsigned d;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: d = {24'd0, c};
      CH_N: d = 32'h0A;
      CH_R: d = 32'h0D;
      CH_T: d = 32'h09;
      CH_B: d = 32'h08;
      CH_F: d = 32'h0C;
      CH_U: begin
        scan_st = ST_HEX_FIRST;
        hex_acc = '0;
        hex_cnt = '0;
        return;
      end
      default: begin
        drop_string();
        return;
      end
    endcase
    emit_byte(d);
    scan_st = ST_BODY;
  endfunction

  function automatic void close_hex(int unsigned cp);
    if (cp >= HI_SURR_FIRST && cp <= HI_SURR_LAST) begin
      high_surr = cp;
      scan_st   = ST_WAIT_BSLASH;
    end else begin
      emit_code_point(cp);
      scan_st = ST_BODY;
    end
  endfunction

  function automatic void hex_byte(logic [7:0] c);
    int          v;
    int unsigned hi;
    int unsigned lo;
    v = hex_digit_value(c);
    if (v < 0) begin
      drop_string();
      return;
    end
    hex_acc = {hex_acc[11:0], v[3:0]};
    hex_cnt++;
    if (hex_cnt < 4) return;
    hex_cnt = '0;
    if (scan_st == ST_HEX_FIRST) begin
      close_hex({16'd0, hex_acc});
      return;
    end
    hi        = high_surr;
    lo        = {16'd0, hex_acc};
    high_surr = 0;
    if (lo >= LO_SURR_FIRST && lo <= LO_SURR_LAST) begin
      emit_code_point(32'h10000 + ((hi - HI_SURR_FIRST) << 10) + (lo - LO_SURR_FIRST));
      scan_st = ST_BODY;
    end else begin
      emit_code_point(hi);
      close_hex(lo);
    end
  endfunction

  function automatic void decode_char(logic [7:0] c);
    int unsigned p;
    decoded_t    d;
    step_items.delete();
    case (scan_st)
      ST_AWAIT_QUOTE: begin
        if (c == CH_QUOTE) begin
          scan_st   = ST_BODY;
          n_written = 0;
          hex_acc   = '0;
          hex_cnt   = '0;
          high_surr = 0;
        end else begin
          drop_string();
        end
      end
      ST_BODY:   body_byte(c);
      ST_ESCAPE: escape_byte(c);
      ST_HEX_FIRST, ST_HEX_SECOND: hex_byte(c);
      ST_WAIT_BSLASH: begin
        if (c == CH_BSLASH) begin
          scan_st = ST_WAIT_U;
        end else begin
          p         = high_surr;
          high_surr = 0;
          emit_code_point(p);
          scan_st = ST_BODY;
          body_byte(c);
        end
      end
      ST_WAIT_U: begin
        if (c == CH_U) begin
          scan_st = ST_HEX_SECOND;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          p         = high_surr;
          high_surr = 0;
          emit_code_point(p);
          escape_byte(c);
        end
      end
      default: drop_string();
    endcase
    for (int i = 0; i < step_items.size(); i++) begin
      d     = step_items[i];
      d.lst = (i == step_items.size() - 1);
      decoded_q.push_back(d);
    end
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t exp_item;
    if (!rst_ni) begin
      scan_st   = ST_AWAIT_QUOTE;
      hex_acc   = '0;
      hex_cnt   = '0;
      high_surr = 0;
      n_written = 0;
      capacity  = 13'd256;
      discard   = 1'b0;
      decoded_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == jsu_pkg::CFG_CAPACITY) capacity = cfg_wdata_i;
        else if (cfg_idx_i == jsu_pkg::CFG_DISCARD) discard = cfg_wdata_i[0];
      end
      if (in_valid_i && in_ready_i) decode_char(in_char_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, byte %02h valid %b finished %b malformed %b last %b",
                   $time, out_byte_i, byte_valid_i, finished_i, malformed_i, last_i);
          fail_count_o++;
        end else begin
          exp_item = decoded_q.pop_front();
          check_field("out_byte", exp_item.data, out_byte_i);
          check_field("byte_valid", {7'b0, exp_item.dvalid}, {7'b0, byte_valid_i});
          check_field("finished", {7'b0, exp_item.fin}, {7'b0, finished_i});
          check_field("malformed", {7'b0, exp_item.bad}, {7'b0, malformed_i});
          check_field("last", {7'b0, exp_item.lst}, {7'b0, last_i});
        end
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the JSON string unescaper testbench: clock, reset, register writes, quoted-string
// stimulus with random idling and a long receiver hold-off, watchdog and verdict.
// Depends on jsu_pkg, json_string_unescape_utf8_top and jsu_unescape_checker.
module testbench;

  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 14;
  localparam int unsigned QUIET_PHASE     = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [jsu_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [jsu_pkg::CAP_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_char;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    out_byte;
  logic                          byte_valid;
  logic                          finished;
  logic                          malformed;
  logic                          last;

  int fail_count;
  int pending;
  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  bit hold_req = 1'b0;
  int n_sent = 0;

  logic [7:0]  simple_escapes [8] = '{8'h22, 8'h5C, 8'h2F, 8'h6E, 8'h72, 8'h74, 8'h62, 8'h66};
  logic [jsu_pkg::CAP_W-1:0] cap_plan [N_PHASES] = '{3, 1, 0, 8191, 256, 7, 2, 4096};
  bit          disc_plan [N_PHASES] = '{0, 0, 0, 0, 1, 0, 1, 0};

  json_string_unescape_utf8_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_char_i    (in_char),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .finished_o   (finished),
    .malformed_o  (malformed),
    .last_o       (last)
  );

  jsu_unescape_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_char_i    (in_char),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_i   (out_byte),
    .byte_valid_i (byte_valid),
    .finished_i   (finished),
    .malformed_i  (malformed),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hold valid high across back-to-back transactions; lower it only for an idle gap.
  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 10) return 8'h30 + d;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + d - 8'd10;
  endfunction

  function automatic logic [7:0] printable_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic send_hex4(input logic [15:0] v);
    send_char(CH_BSLASH);
    send_char(CH_U);
    for (int i = 3; i >= 0; i--) send_char(hex_digit(v[4*i +: 4]));
  endtask

  task automatic send_element();
    case ($urandom_range(9))
      0, 1, 2: send_char(printable_byte());
      3: send_char(8'($urandom_range(255, 128)));
      4: begin
        send_char(CH_BSLASH);
        send_char(simple_escapes[$urandom_range(7)]);
      end
      5: begin
        case ($urandom_range(3))
          0: send_hex4(16'($urandom_range(16'h7F)));
          1: send_hex4(16'($urandom_range(16'h7FF, 16'h80)));
          2: send_hex4(16'($urandom_range(16'hFFFF, 16'h800)));
          default: send_hex4(16'($urandom_range(16'hFFFF)));
        endcase
      end
      6: begin
        send_hex4(16'hD800 | 16'($urandom_range(16'h3FF)));
        send_hex4(16'hDC00 | 16'($urandom_range(16'h3FF)));
      end
      7: send_hex4(16'hD800 | 16'($urandom_range(16'h3FF)));
      8: send_hex4(16'hDC00 | 16'($urandom_range(16'h3FF)));
      default: send_hex4(16'($urandom_range(16'h7FF, 16'h80)));
    endcase
  endtask

  task automatic send_random_string();
    int         r;
    bit         ok;
    logic [7:0] c;
    if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)));
    send_char(CH_QUOTE);
    repeat ($urandom_range(8)) send_element();
    r = $urandom_range(99);
    if (r < 80) begin
      send_char(CH_QUOTE);
    end else if (r < 85) begin
      send_char(8'h00);
    end else if (r < 90) begin
      do begin
        c  = 8'($urandom_range(255));
        ok = (c != CH_U);
        foreach (simple_escapes[i]) if (c == simple_escapes[i]) ok = 1'b0;
      end while (!ok);
      send_char(CH_BSLASH);
      send_char(c);
    end else if (r < 95) begin
      do c = 8'($urandom_range(255));
      while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66));
      send_char(CH_BSLASH);
      send_char(CH_U);
      repeat ($urandom_range(3)) send_char(hex_digit(4'($urandom_range(15))));
      send_char(c);
    end
  endtask

  task automatic write_reg(input logic [jsu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jsu_pkg::CAP_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid, wait for every predicted item, then let trailing bytes clear the pipe.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int goal;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_char   = 8'h00;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_char(8'h78);
    send_char(8'h00);
    send_char(CH_QUOTE);
    send_char(8'hFF);
    send_text("\\uD83D\\ude00\"");
    send_text("\"\\q");
    send_text("\"\\u12G");

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_reg(jsu_pkg::CFG_CAPACITY, cap_plan[p]);
      write_reg(jsu_pkg::CFG_DISCARD, {{(jsu_pkg::CAP_W-1){1'b0}}, disc_plan[p]});
      tx_idle_pct = (p == QUIET_PHASE) ? 0 : 30;
      rx_idle_pct = (p == QUIET_PHASE) ? 0 : 30;
      if (p == N_PHASES - 1) begin
        hold_req = 1'b1;
        send_char(CH_QUOTE);
        repeat (60) send_char(printable_byte());
        send_char(CH_QUOTE);
      end
      goal = n_sent + ITEMS_PER_PHASE;
      while (n_sent < goal) send_random_string();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
